FILE: hw/rtl/osa_pkg.sv
// Shared request and response types and codes for the ordered slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package osa_pkg;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_REFUSED   = 2'd1;
    localparam logic [1:0] ST_DRAINED   = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    typedef struct packed {
        logic       func;
        logic [7:0] order;
    } t_req;

    typedef struct packed {
        logic [6:0] slot;
        logic [6:0] position;
        logic [1:0] status;
        logic       last;
    } t_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/osa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module osa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_slot_allocator_top.sv
// Top level of the ordered slot allocator: control FSM around head, tail and link RAMs.
`timescale 1ns / 1ps
`default_nettype none

// Slots 0, 1, 2, ... are handed out by allocate requests and appended to one of LEVELS
// order buckets (order above LEVELS-1 saturates). Drain requests then return the slots
// one per request, lowest bucket first and in allocation order within a bucket, each
// with its draw position; the final drain flags last and empties the store, as does a
// drain that finds nothing. Allocates while full or during a drain are refused.
// States: an allocate passes S_ALLOC, a refusal or an empty drain S_EMIT; a drain
// passes S_STEP, after S_HEAD when it starts the drain sequence and then S_NEXT when
// it moves to the next bucket. Each extra state is a dependent read of the bucket head
// RAM, whose read data is registered. One request is in flight at a time; a finished
// response waits in the output register while the next request is taken.
module ordered_slot_allocator_top #(
    parameter int SLOTS  = 128,
    parameter int LEVELS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire osa_pkg::t_req i_in_req,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output osa_pkg::t_rsp      o_out_rsp
);

    localparam int SW = $clog2(SLOTS);
    localparam int UW = $clog2(SLOTS + 1);
    localparam int LW = $clog2(LEVELS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ALLOC = 6'b000010,
        S_HEAD  = 6'b000100,
        S_STEP  = 6'b001000,
        S_NEXT  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [LEVELS-1:0] r_hv, n_hv;          // bucket head written since last clear
    logic [UW-1:0] r_used, n_used;
    logic          r_draining, n_draining;
    logic [LW-1:0] r_dbucket, n_dbucket;
    logic [SW-1:0] r_dslot, n_dslot;
    logic [6:0]    r_dpos, n_dpos;
    logic [LW-1:0] r_ord, n_ord;
    osa_pkg::t_rsp r_res, n_res;
    logic          r_ov, n_ov;
    osa_pkg::t_rsp r_out, n_out;

    logic          head_we, tail_we, link_we;
    logic [LW-1:0] head_raddr, tail_raddr;
    logic [SW-1:0] link_raddr, link_waddr;
    logic [SW-1:0] head_rdata, tail_rdata, link_rdata;
    logic [SW-1:0] alloc_slot;

    logic          first_found, next_found;
    logic [LW-1:0] first_b, next_b;
    logic          out_free;
    logic          in_acc;
    logic [LW-1:0] sat_ord;

    osa_ram #(.WIDTH(SW), .DEPTH(LEVELS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_ord),
        .i_wdata (alloc_slot),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    osa_ram #(.WIDTH(SW), .DEPTH(LEVELS)) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (tail_we),
        .i_waddr (r_ord),
        .i_wdata (alloc_slot),
        .i_raddr (tail_raddr),
        .o_rdata (tail_rdata)
    );

    osa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (alloc_slot),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // Lowest nonempty bucket overall, and lowest one above the bucket being drained.
    always_comb begin
        first_found = 1'b0;
        first_b     = '0;
        next_found  = 1'b0;
        next_b      = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_hv[i]) begin
                first_found = 1'b1;
                first_b     = LW'(i);
                if (LW'(i) > r_dbucket) begin
                    next_found = 1'b1;
                    next_b     = LW'(i);
                end
            end
        end
    end

    assign alloc_slot = r_used[SW-1:0];
    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign sat_ord    = (i_in_req.order > 8'(LEVELS - 1)) ? LW'(LEVELS - 1)
                                                          : i_in_req.order[LW-1:0];
    assign o_out_valid = r_ov;
    assign o_out_rsp   = r_out;

    always_comb begin
        n_state    = r_state;
        n_hv       = r_hv;
        n_used     = r_used;
        n_draining = r_draining;
        n_dbucket  = r_dbucket;
        n_dslot    = r_dslot;
        n_dpos     = r_dpos;
        n_ord      = r_ord;
        n_res      = r_res;
        n_ov       = r_ov && i_out_stall;
        n_out      = r_out;
        head_we    = 1'b0;
        tail_we    = 1'b0;
        link_we    = 1'b0;
        link_waddr = tail_rdata;
        head_raddr = '0;
        tail_raddr = '0;
        link_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_req.func == osa_pkg::FUNC_ALLOC) begin
                        if (r_draining || r_used >= UW'(SLOTS)) begin
                            n_res   = '{slot: '0, position: '0,
                                        status: osa_pkg::ST_REFUSED, last: 1'b0};
                            n_state = S_EMIT;
                        end else begin
                            n_ord      = sat_ord;
                            tail_raddr = sat_ord;
                            n_state    = S_ALLOC;
                        end
                    end else if (r_draining) begin
                        link_raddr = r_dslot;
                        tail_raddr = r_dbucket;
                        n_state    = S_STEP;
                    end else if (r_used == '0 || !first_found) begin
                        n_hv      = '0;
                        n_used    = '0;
                        n_dbucket = '0;
                        n_dpos    = '0;
                        n_res     = '{slot: '0, position: '0,
                                      status: osa_pkg::ST_NONE, last: 1'b0};
                        n_state   = S_EMIT;
                    end else begin
                        n_draining = 1'b1;
                        n_dbucket  = first_b;
                        n_dpos     = '0;
                        head_raddr = first_b;
                        n_state    = S_HEAD;
                    end
                end
            end

            S_ALLOC: begin
                tail_we = 1'b1;
                if (r_hv[r_ord]) begin
                    link_we = 1'b1;
                end else begin
                    head_we     = 1'b1;
                    n_hv[r_ord] = 1'b1;
                end
                n_used = r_used + UW'(1);
                n_res  = '{slot: 7'(alloc_slot), position: '0,
                           status: osa_pkg::ST_ALLOCATED, last: 1'b0};
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_out   = n_res;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end

            S_HEAD: begin
                n_dslot    = head_rdata;
                link_raddr = head_rdata;
                tail_raddr = r_dbucket;
                n_state    = S_STEP;
            end

            S_STEP: begin
                n_dpos = r_dpos + 7'd1;
                n_res  = '{slot: 7'(r_dslot), position: r_dpos,
                           status: osa_pkg::ST_DRAINED, last: 1'b0};
                if (r_dslot != tail_rdata) begin
                    n_dslot = link_rdata;
                end else if (next_found) begin
                    n_dbucket  = next_b;
                    head_raddr = next_b;
                end else begin
                    // final slot: empty the store
                    n_res.last = 1'b1;
                    n_hv       = '0;
                    n_used     = '0;
                    n_draining = 1'b0;
                    n_dbucket  = '0;
                    n_dpos     = '0;
                end
                if (r_dslot == tail_rdata && next_found) begin
                    n_state = S_NEXT;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_out   = n_res;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end

            S_NEXT: begin
                n_dslot = head_rdata;
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hv       <= '0;
            r_used     <= '0;
            r_draining <= 1'b0;
            r_dbucket  <= '0;
            r_dpos     <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hv       <= n_hv;
            r_used     <= n_used;
            r_draining <= n_draining;
            r_dbucket  <= n_dbucket;
            r_dpos     <= n_dpos;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dslot <= n_dslot;
        r_ord   <= n_ord;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the ordered slot allocator: directed and random requests.
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_SLOTS   = 128;
    localparam int NUM_LEVELS  = 32;
    localparam logic [7:0] NO_SLOT = 8'hFF;
    localparam int RANDOM_REQS = 1300;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 12;
    localparam int MAX_PRINTS  = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    osa_pkg::t_req i_in_req = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    osa_pkg::t_rsp o_out_rsp;

    ordered_slot_allocator_top #(
        .SLOTS (NUM_SLOTS),
        .LEVELS(NUM_LEVELS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_rsp  (o_out_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Predicted allocator state
    logic [7:0] head_q [NUM_LEVELS];
    logic [6:0] tail_q [NUM_LEVELS];
    logic [7:0] link_q [NUM_SLOTS];
    logic [7:0] used_cnt;
    logic [4:0] drain_bkt;
    logic [7:0] drain_slot;
    logic [6:0] drain_pos;
    logic       pred_draining;

    osa_pkg::t_rsp awaited_rsp_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int req_count = 0;
    int cycle_count = 0;
    int error_count = 0;
    int alloc_seen = 0;
    int drained_seen = 0;
    int refused_seen = 0;
    int empty_seen = 0;
    int last_seen = 0;

    function automatic void empty_store();
        for (int b = 0; b < NUM_LEVELS; b++) begin
            head_q[b] = NO_SLOT;
            tail_q[b] = 7'h7F;
        end
        used_cnt = '0;
        drain_bkt = '0;
        drain_slot = NO_SLOT;
        drain_pos = '0;
        pred_draining = 1'b0;
    endfunction

    function automatic int first_bucket(input int start);
        for (int b = start; b < NUM_LEVELS; b++) begin
            if (head_q[b] != NO_SLOT && head_q[b] < NUM_SLOTS)
                return b;
        end
        return NUM_LEVELS;
    endfunction

    // Updates the predicted store for one request and returns its response.
    function automatic osa_pkg::t_rsp allocate_or_drain(input osa_pkg::t_req req);
        osa_pkg::t_rsp rsp;
        int ord;
        int b;
        int nxt;
        int s;
        rsp = '0;
        if (req.func == osa_pkg::FUNC_ALLOC) begin
            if (pred_draining || used_cnt >= NUM_SLOTS) begin
                rsp.status = osa_pkg::ST_REFUSED;
            end else begin
                ord = (req.order > NUM_LEVELS - 1) ? NUM_LEVELS - 1 : int'(req.order);
                s = int'(used_cnt);
                link_q[s] = NO_SLOT;
                if (head_q[ord] == NO_SLOT)
                    head_q[ord] = s[7:0];
                else if (tail_q[ord] < NUM_SLOTS)
                    link_q[tail_q[ord]] = s[7:0];
                tail_q[ord] = s[6:0];
                used_cnt = used_cnt + 8'd1;
                rsp.slot = s[6:0];
                rsp.status = osa_pkg::ST_ALLOCATED;
            end
            return rsp;
        end
        if (!pred_draining) begin
            b = first_bucket(0);
            if (used_cnt == 0 || b >= NUM_LEVELS) begin
                empty_store();
                rsp.status = osa_pkg::ST_NONE;
                return rsp;
            end
            pred_draining = 1'b1;
            drain_bkt = b[4:0];
            drain_slot = head_q[b];
            drain_pos = '0;
        end
        rsp.slot = drain_slot[6:0];
        rsp.position = drain_pos;
        rsp.status = osa_pkg::ST_DRAINED;
        drain_pos = drain_pos + 7'd1;
        nxt = (drain_slot < NUM_SLOTS) ? int'(link_q[drain_slot[6:0]]) : int'(NO_SLOT);
        if (nxt != NO_SLOT && nxt < NUM_SLOTS) begin
            drain_slot = nxt[7:0];
        end else begin
            b = first_bucket(int'(drain_bkt) + 1);
            if (b >= NUM_LEVELS) begin
                rsp.last = 1'b1;
                empty_store();
            end else begin
                drain_bkt = b[4:0];
                drain_slot = head_q[b];
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // One request; called at a rising edge, returns at the edge that accepted it.
    task automatic send_req(input logic func, input logic [7:0] order);
        osa_pkg::t_req req;
        req.func = func;
        req.order = order;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        do @(posedge i_clk); while (o_in_stall);
        awaited_rsp_q.push_back(allocate_or_drain(req));
        req_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, awaited_rsp_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : rsp_check
        osa_pkg::t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_rsp_q.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                want = awaited_rsp_q.pop_front();
                if (o_out_rsp.slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d",
                                              o_out_rsp.slot, want.slot));
                if (o_out_rsp.position !== want.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              o_out_rsp.position, want.position));
                if (o_out_rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_out_rsp.status, want.status));
                if (o_out_rsp.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              o_out_rsp.last, want.last));
                case (want.status)
                    osa_pkg::ST_ALLOCATED: alloc_seen++;
                    osa_pkg::ST_REFUSED:   refused_seen++;
                    osa_pkg::ST_DRAINED:   drained_seen++;
                    default:               empty_seen++;
                endcase
                if (want.last)
                    last_seen++;
            end
        end
    end

    // 0: few buckets, 1: all buckets, 2: any byte, 3: mostly saturating
    function automatic logic [7:0] pick_order(input int mode);
        case (mode)
            0:       return 8'($urandom_range(0, 3));
            1:       return 8'($urandom_range(0, NUM_LEVELS - 1));
            2:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(NUM_LEVELS - 4, 255));
        endcase
    endfunction

    // Allocate a batch, then drain to the end with refused allocates mixed in.
    task automatic run_session(input int n_alloc, input int mode);
        for (int i = 0; i < n_alloc; i++)
            send_req(osa_pkg::FUNC_ALLOC, pick_order(mode));
        while (used_cnt != 0) begin
            if (pred_draining && $urandom_range(0, 9) == 0)
                send_req(osa_pkg::FUNC_ALLOC, pick_order(2));
            else
                send_req(osa_pkg::FUNC_DRAIN, pick_order(2));
        end
        if ($urandom_range(0, 3) == 0)
            send_req(osa_pkg::FUNC_DRAIN, pick_order(2));
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            send_req(logic'($urandom_range(0, 1)), pick_order(2));
    endtask

    task automatic test_empty_drain();
        send_req(osa_pkg::FUNC_DRAIN, 8'h00);
        send_req(osa_pkg::FUNC_DRAIN, 8'hFF);
    endtask

    // Bucket ordering, saturation above the top bucket, last flag
    task automatic test_order_saturation();
        send_req(osa_pkg::FUNC_ALLOC, 8'd31);
        send_req(osa_pkg::FUNC_ALLOC, 8'd32);
        send_req(osa_pkg::FUNC_ALLOC, 8'd255);
        send_req(osa_pkg::FUNC_ALLOC, 8'd0);
        send_req(osa_pkg::FUNC_ALLOC, 8'd128);
        send_req(osa_pkg::FUNC_ALLOC, 8'd5);
        send_req(osa_pkg::FUNC_ALLOC, 8'd0);
        send_req(osa_pkg::FUNC_ALLOC, 8'd31);
        send_req(osa_pkg::FUNC_ALLOC, 8'd127);
        while (used_cnt != 0)
            send_req(osa_pkg::FUNC_DRAIN, 8'h55);
        send_req(osa_pkg::FUNC_DRAIN, 8'hAA);
    endtask

    task automatic test_alloc_during_drain();
        send_req(osa_pkg::FUNC_ALLOC, 8'd3);
        send_req(osa_pkg::FUNC_ALLOC, 8'd1);
        send_req(osa_pkg::FUNC_DRAIN, 8'd0);
        send_req(osa_pkg::FUNC_ALLOC, 8'd0);
        send_req(osa_pkg::FUNC_DRAIN, 8'd0);
        send_req(osa_pkg::FUNC_ALLOC, 8'd7);
        send_req(osa_pkg::FUNC_DRAIN, 8'd0);
    endtask

    task automatic test_store_full();
        run_session(NUM_SLOTS + 2, 1);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n_reqs);
        int target;
        int pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        target = req_count + n_reqs;
        run_session(NUM_SLOTS + $urandom_range(0, 3), $urandom_range(0, 3));
        while (req_count < target) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_noise();
            else if (pick == 1)
                run_session(NUM_SLOTS + $urandom_range(0, 3), $urandom_range(0, 3));
            else
                run_session($urandom_range(0, 24), $urandom_range(0, 3));
        end
    endtask

    initial begin
        empty_store();
        for (int b = 0; b < NUM_LEVELS; b++)
            tail_q[b] = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
            link_q[s] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_drain();
        test_order_saturation();
        test_alloc_during_drain();
        test_store_full();
        test_random_phase(0, 0, RANDOM_REQS / 4);
        test_random_phase(80, 0, RANDOM_REQS / 4);
        test_random_phase(0, 80, RANDOM_REQS / 4);
        test_random_phase(34, 34, RANDOM_REQS / 4);
        i_in_valid <= 1'b0;

        while (awaited_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests over %0d cycles, with and without idling and stalls",
                 req_count, cycle_count);
        $display("Saw %0d allocs, %0d drains (%0d final), %0d refusals, %0d empty drains",
                 alloc_seen, drained_seen, last_seen, refused_seen, empty_seen);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
